FILE: hdl/ready_queue_fifo_with_idle_top_defines.svh
// ----------------------------------------------------------------------------
// Ready queue assertion macros
// Concurrent assertion helpers, sampled on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef READY_QUEUE_FIFO_WITH_IDLE_TOP_DEFINES_SVH
`define READY_QUEUE_FIFO_WITH_IDLE_TOP_DEFINES_SVH

// Plain check with a fixed message.
`define RQFI_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("rqfi assertion failed");

// Check with a caller message.
`define RQFI_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

`endif

FILE: hdl/rqfi_pkg.sv
// ----------------------------------------------------------------------------
// rqfi_pkg
// Shared types and codes for the ready queue.
// ----------------------------------------------------------------------------
package rqfi_pkg;

  localparam int unsigned IdW = 16;

  typedef enum logic [1:0] {
    MODE_PUT    = 2'd0,
    MODE_GET    = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_NOP    = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  // Broadcast to every cell for the current word.
  typedef struct packed {
    logic           put_en;   // append at the cell whose index equals count
    logic           get_en;   // shift the whole row toward the head
    logic           rem_en;   // compare entries against tid
    logic [IdW-1:0] tid;
  } cell_ctrl_t;

endpackage

FILE: hdl/ready_queue_fifo_with_idle_top.sv
// ----------------------------------------------------------------------------
// ready_queue_fifo_with_idle_top
// FIFO thread ready queue with an idle thread and removal by id.
// ----------------------------------------------------------------------------
//
//  channel   | handshake                 | data
//  ----------+---------------------------+-------------------------------
//  command   | start_i, busy_o           | mode_i, thread_id_i
//  result    | done_o (one-cycle strobe) | result_id_o, status_o
//  config    | idle_id_we_i              | idle_id_i
//
//  A command word is taken at each edge with start_i high and busy_o low;
//  busy_o stays low, so one word is taken per cycle.
//  Its result shows on the cycle after acceptance, strobed by done_o for one
//  cycle; the receiver cannot stall it.
//  The rate is set by the cell row: all cells update together on each edge, and the
//  remove match travels down the row as a hit chain within the same cycle.
//  Reset (rst_ni low, async) empties the queue and sets idle_id to zero;
//  queue slots themselves are not cleared.
//
module ready_queue_fifo_with_idle_top
  import rqfi_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  logic [1:0]     mode_i,
  input  logic [IdW-1:0] thread_id_i,
  output logic           done_o,
  output logic [IdW-1:0] result_id_o,
  output logic [1:0]     status_o,
  input  logic           idle_id_we_i,
  input  logic [IdW-1:0] idle_id_i
);

  `include "ready_queue_fifo_with_idle_top_defines.svh"

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  logic [CntW-1:0] count_q, count_d;
  logic [IdW-1:0]  idle_id_q;
  logic            done_q;
  logic [IdW-1:0]  result_id_q, result_id_d;
  status_e         status_q, status_d;

  logic            accept, full, empty, found;
  cell_ctrl_t      ctrl;

  // Row links: index QUEUE_DEPTH is the empty space above the top cell.
  logic [IdW-1:0]  entry [QUEUE_DEPTH+1];
  logic            hit   [QUEUE_DEPTH+1];

  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;
  assign full   = (count_q == CntW'(QUEUE_DEPTH));
  assign empty  = (count_q == '0);
  assign found  = hit[0];

  assign entry[QUEUE_DEPTH] = '0;
  assign hit[QUEUE_DEPTH]   = 1'b0;

  // Cell broadcast; kept apart from the result decode since the match
  // chain feeds found back into that decode.
  always_comb begin
    ctrl     = '0;
    ctrl.tid = thread_id_i;
    if (accept) begin
      case (mode_e'(mode_i))
        MODE_PUT: begin
          ctrl.put_en = ~full;
        end
        MODE_GET: begin
          ctrl.get_en = ~empty;
        end
        MODE_REMOVE: begin
          // The idle thread is never removed, even if queued.
          ctrl.rem_en = (thread_id_i != idle_id_q);
        end
        default: begin
        end
      endcase
    end
  end

  // Decode the command into the next fill level and the result word.
  always_comb begin
    count_d     = count_q;
    result_id_d = '0;
    status_d    = ST_DONE;
    if (accept) begin
      case (mode_e'(mode_i))
        MODE_PUT: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            count_d = count_q + 1'b1;
          end
        end
        MODE_GET: begin
          if (empty) begin
            result_id_d = idle_id_q;
            status_d    = ST_EMPTY;
          end else begin
            result_id_d = entry[0];
            count_d     = count_q - 1'b1;
          end
        end
        MODE_REMOVE: begin
          if (thread_id_i != idle_id_q) begin
            if (found) begin
              count_d = count_q - 1'b1;
            end else begin
              status_d = ST_NOTFOUND;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    rqfi_cell #(
      .Idx  (i),
      .CntW (CntW)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .count_i     (count_q),
      .found_i     (found),
      .up_entry_i  (entry[i+1]),
      .hit_above_i (hit[i+1]),
      .entry_o     (entry[i]),
      .hit_o       (hit[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      idle_id_q <= '0;
      done_q    <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= accept;
      if (idle_id_we_i) begin
        idle_id_q <= idle_id_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    result_id_q <= result_id_d;
    status_q    <= status_d;
  end

  assign done_o      = done_q;
  assign result_id_o = result_id_q;
  assign status_o    = status_q;

  // Fill level never passes the row length.
  `RQFI_ASSERT(a_count_bound, count_q <= CntW'(QUEUE_DEPTH))
  // Every accepted word gives one result, and nothing else does.
  `RQFI_ASSERT_MSG(a_done_follows, accept |=> done_o, "accepted word gave no result")
  `RQFI_ASSERT_MSG(a_no_spurious, !accept |=> !done_o, "result without a word")
  // A put on a full row is flagged and leaves the fill level alone.
  `RQFI_ASSERT(a_full_drop,
    (accept && mode_i == MODE_PUT && full) |=> (status_o == ST_FULL && count_q == $past(count_q)))
  // A get on a non-empty row pops exactly one entry.
  `RQFI_ASSERT(a_get_pop,
    (accept && mode_i == MODE_GET && !empty) |=>
      (status_o == ST_DONE && count_q == $past(count_q) - 1'b1))

endmodule

FILE: hdl/rqfi_cell.sv
// ----------------------------------------------------------------------------
// rqfi_cell
// One queue slot: holds an id, compares it, and loads from its upper neighbor.
// ----------------------------------------------------------------------------
module rqfi_cell
  import rqfi_pkg::*;
#(
  parameter int unsigned Idx = 0,
  parameter int unsigned CntW = 5
) (
  input  logic            clk_i,
  input  cell_ctrl_t      ctrl_i,
  input  logic [CntW-1:0] count_i,
  input  logic            found_i,      // some cell matched this remove
  input  logic [IdW-1:0]  up_entry_i,
  input  logic            hit_above_i,  // a valid match sits above this cell
  output logic [IdW-1:0]  entry_o,
  output logic            hit_o
);

  logic [IdW-1:0] entry_q, entry_d;
  logic           occupied, match, shift;

  assign occupied = (CntW'(Idx) < count_i);
  assign match    = ctrl_i.rem_en && occupied && (entry_q == ctrl_i.tid);
  assign hit_o    = hit_above_i | match;

  // Cells at or above the removed slot close the gap.
  assign shift = ctrl_i.get_en | (found_i & ~hit_above_i);

  always_comb begin
    entry_d = entry_q;
    if (shift) begin
      entry_d = up_entry_i;
    end else if (ctrl_i.put_en && (count_i == CntW'(Idx))) begin
      entry_d = ctrl_i.tid;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

FILE: tb/ready_queue_checker.sv
// ----------------------------------------------------------------------------
// ready_queue_checker
// Watches the command, result and idle id ports of the ready queue. It keeps
// its own copy of the queue to predict every result word, and compares each
// strobed result against the oldest prediction.
// ----------------------------------------------------------------------------
module ready_queue_checker
  import rqfi_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic           busy_i,
  input  logic [1:0]     mode_i,
  input  logic [IdW-1:0] thread_id_i,
  input  logic           done_i,
  input  logic [IdW-1:0] result_id_i,
  input  logic [1:0]     status_i,
  input  logic           idle_id_we_i,
  input  logic [IdW-1:0] idle_id_i,
  output int             error_count_o,
  output int             outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [IdW-1:0] id;
    status_e        st;
  } sched_result_t;

  logic [IdW-1:0] ready_ids[$];     // oldest at index 0
  logic [IdW-1:0] idle_thread = '0;
  sched_result_t  due_results[$];
  int             mismatches = 0;
  int             n_due = 0;

  assign error_count_o = mismatches;
  assign outstanding_o = n_due;

  task automatic report_mismatch(input string what);
    // keep the log bounded on a badly broken build
    if (mismatches < 200) $display("MISMATCH @%0t: %s", $time, what);
    mismatches++;
  endtask

  // Applies one command word to the queue copy and returns its result.
  function automatic sched_result_t schedule_step(mode_e op, logic [IdW-1:0] tid);
    sched_result_t r;
    int hit;
    r.id = '0;
    r.st = ST_DONE;
    hit = -1;
    case (op)
      MODE_PUT: begin
        if (ready_ids.size() >= QUEUE_DEPTH) r.st = ST_FULL;
        else ready_ids.push_back(tid);
      end
      MODE_GET: begin
        if (ready_ids.size() == 0) begin
          r.id = idle_thread;
          r.st = ST_EMPTY;
        end else begin
          r.id = ready_ids.pop_front();
        end
      end
      MODE_REMOVE: begin
        // idle id is never removed, even when queued
        if (tid != idle_thread) begin
          for (int i = ready_ids.size() - 1; i >= 0 && hit < 0; i--)
            if (ready_ids[i] == tid) hit = i;
          if (hit < 0) r.st = ST_NOTFOUND;
          else ready_ids.delete(hit);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk_i) begin
    sched_result_t oldest;
    if (!rst_ni) begin
      ready_ids.delete();
      due_results.delete();
      idle_thread = '0;
    end else begin
      // results leave before the word taken at this edge is queued
      if (done_i === 1'b1) begin
        if (due_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result id=%h status=%0d",
                                    result_id_i, status_i));
        end else begin
          oldest = due_results.pop_front();
          if (result_id_i !== oldest.id)
            report_mismatch($sformatf("result_id %h, expected %h", result_id_i, oldest.id));
          if (status_i !== oldest.st)
            report_mismatch($sformatf("status %0d, expected %s", status_i, oldest.st.name()));
        end
      end else if (done_i !== 1'b0) begin
        report_mismatch("done strobe unknown");
      end
      if (start_i === 1'b1 && busy_i === 1'b0)
        due_results.push_back(schedule_step(mode_e'(mode_i), thread_id_i));
      if (idle_id_we_i === 1'b1) idle_thread = idle_id_i;
    end
    n_due = due_results.size();
  end

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// Ready queue testbench
// Drives command words into the ready queue and idle id writes between
// phases. A directed opener covers empty gets, removes of missing and idle
// ids, duplicates, a full queue and the no-op mode; random phases follow with
// bursty put/get mixes so the queue swings between empty and full. The
// checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rqfi_pkg::*;

  localparam int unsigned QUEUE_DEPTH = 16;

  logic           clk_i;
  logic           rst_ni;
  logic           start_i;
  logic           busy_o;
  logic [1:0]     mode_i;
  logic [IdW-1:0] thread_id_i;
  logic           done_o;
  logic [IdW-1:0] result_id_o;
  logic [1:0]     status_o;
  logic           idle_id_we_i;
  logic [IdW-1:0] idle_id_i;
  int             error_count;
  int             outstanding;

  ready_queue_fifo_with_idle_top #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .mode_i      (mode_i),
    .thread_id_i (thread_id_i),
    .done_o      (done_o),
    .result_id_o (result_id_o),
    .status_o    (status_o),
    .idle_id_we_i(idle_id_we_i),
    .idle_id_i   (idle_id_i)
  );

  ready_queue_checker #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_i       (busy_o),
    .mode_i       (mode_i),
    .thread_id_i  (thread_id_i),
    .done_i       (done_o),
    .result_id_i  (result_id_o),
    .status_i     (status_o),
    .idle_id_we_i (idle_id_we_i),
    .idle_id_i    (idle_id_i),
    .error_count_o(error_count),
    .outstanding_o(outstanding)
  );

  // 4 ns clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #2ms;
    $display("DONE: errors detected");
    $finish;
  end

  // Small pool so removes often hit queued ids and duplicates build up;
  // the extremes are in it, and the idle id settings come from it too.
  function automatic logic [IdW-1:0] pool_id(int unsigned k);
    case (k)
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h0005;
      3:       return 16'h8000;
      4:       return 16'h7FFF;
      5:       return 16'h00FF;
      6:       return 16'h1234;
      default: return 16'hA5A5;
    endcase
  endfunction

  // Mostly pool ids, the rest full range so every bit toggles.
  function automatic logic [IdW-1:0] pick_thread_id();
    logic [IdW-1:0] id;
    if ($urandom_range(9) < 7) id = pool_id($urandom_range(7));
    else id = IdW'($urandom);
    return id;
  endfunction

  // One word per call; start_i stays high into the next call when no gap
  // follows, so start_i is never dropped and raised in one step.
  task automatic send_word(input mode_e op, input logic [IdW-1:0] tid);
    @(negedge clk_i);
    start_i     <= 1'b1;
    mode_i      <= op;
    thread_id_i <= tid;
    do @(posedge clk_i); while (busy_o !== 1'b0);
  endtask

  task automatic sender_gap(input int unsigned pct);
    while ($urandom_range(99) < pct) begin
      @(negedge clk_i);
      start_i <= 1'b0;
    end
  endtask

  // Stop sending until every predicted result has come back.
  task automatic drain_results();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
  endtask

  // Register writes only with the queue idle; every word gives one result,
  // so an empty prediction list means nothing is in flight.
  task automatic write_idle_id(input logic [IdW-1:0] value);
    drain_results();
    @(negedge clk_i);
    idle_id_we_i <= 1'b1;
    idle_id_i    <= value;
    @(negedge clk_i);
    idle_id_we_i <= 1'b0;
    idle_id_i    <= IdW'($urandom);  // data ignored without the enable
  endtask

  // Random words in bursts of 32 with a fixed put share per burst, so the
  // queue fills up (full drops) and runs dry (idle returns) repeatedly.
  task automatic random_phase(input int unsigned n_words, input int unsigned gap_pct);
    int unsigned put_pct;
    int unsigned r;
    mode_e       op;
    put_pct = 50;
    for (int unsigned k = 0; k < n_words; k++) begin
      if (k % 32 == 0) begin
        case ($urandom_range(2))
          0:       put_pct = 20;
          1:       put_pct = 50;
          default: put_pct = 85;
        endcase
      end
      if ($urandom_range(99) == 0) drain_results();
      sender_gap(gap_pct);
      r = $urandom_range(99);
      if (r < 4) op = MODE_NOP;
      else if ($urandom_range(99) < put_pct) op = MODE_PUT;
      else if ($urandom_range(9) < 6) op = MODE_GET;
      else op = MODE_REMOVE;
      send_word(op, pick_thread_id());
    end
  endtask

  initial begin
    // every input known from time zero
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    mode_i       = MODE_NOP;
    thread_id_i  = '0;
    idle_id_we_i = 1'b0;
    idle_id_i    = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty get right after reset returns the reset idle id (zero)
    send_word(MODE_GET, 16'hFFFF);
    write_idle_id(16'h0005);

    // empty queue: missing id, idle id, no-op
    send_word(MODE_REMOVE, 16'h1234);
    send_word(MODE_REMOVE, 16'h0005);
    send_word(MODE_NOP, 16'hFFFF);

    // extremes, the idle id itself, and a duplicate
    send_word(MODE_PUT, 16'h0000);
    send_word(MODE_PUT, 16'hFFFF);
    send_word(MODE_PUT, 16'h0005);
    send_word(MODE_PUT, 16'hA5A5);
    send_word(MODE_PUT, 16'hFFFF);
    // drops the newer duplicate, closing the gap
    send_word(MODE_REMOVE, 16'hFFFF);
    // idle id is queued but must stay
    send_word(MODE_REMOVE, 16'h0005);
    send_word(MODE_GET, 16'h0000);

    // fill to the top, then one put past it gets dropped
    for (int k = 0; k < 13; k++) send_word(MODE_PUT, IdW'(16'h0100 + k));
    send_word(MODE_PUT, 16'h5A5A);
    send_word(MODE_GET, 16'h0000);

    // random phases: light sender gaps, heavy gaps, then back to back
    write_idle_id(16'h0000);
    random_phase(608, 13);
    write_idle_id(16'hFFFF);
    random_phase(608, 53);
    write_idle_id(pool_id($urandom_range(7)));
    random_phase(608, 0);

    // wait out the last results, then watch for any stray strobe
    drain_results();
    repeat (4) @(posedge clk_i);

    if (error_count == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
